>>> design/ikts_pkg.sv
`default_nettype none
package ikts_pkg;

  // Fixed-point settings of the angle path.
  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int ANGLE_FRACTION_BITS  = 8;
  localparam int ZQ                   = 24;
  localparam int ANGLE_SHIFT          = ZQ - ANGLE_FRACTION_BITS;
  localparam int CW                   = 34;

  // Register indexes on the configuration channel.
  localparam logic [2:0] REG_UPPER_LINK = 3'd0;
  localparam logic [2:0] REG_LOWER_LINK = 3'd1;
  localparam logic [2:0] REG_TOOL       = 3'd2;
  localparam logic [2:0] REG_MODE       = 3'd3;
  localparam logic [2:0] REG_JOINT_LIM  = 3'd4;
  localparam logic [2:0] REG_ELBOW_ALT  = 3'd5;

  localparam logic [13:0] UPPER_RESET     = 14'd1600;
  localparam logic [13:0] LOWER_RESET     = 14'd1600;
  localparam logic [11:0] TOOL_RESET      = 12'd528;
  localparam logic        MODE_RESET      = 1'b0;
  localparam logic [15:0] JOINT_LIM_RESET = 16'd30720;
  localparam logic [15:0] ELBOW_ALT_RESET = 16'd32000;

  typedef struct packed {
    logic [13:0] upper_link_length;
    logic [13:0] lower_link_length;
    logic [11:0] tool_offset;
    logic        selection_mode;
    logic [15:0] joint_limit;
    logic [15:0] elbow_limit_alternate;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] target_y;
    logic signed [15:0] target_x;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] yv;
    logic signed [CW-1:0] xv;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [16:0] angle;
  } cordic_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MXX, ST_MYY, ST_ML1, ST_ML2, ST_ML12, ST_DCHK, ST_DIV,
    ST_CSQ, ST_SQRT, ST_AT1S, ST_AT1W, ST_ML2S, ST_ML2C, ST_AT2S, ST_AT2W,
    ST_AT3S, ST_AT3W, ST_SEL, ST_DIST, ST_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    CS_IDLE, CS_NORM, CS_ITER, CS_CLAMP, CS_ROUND
  } cordic_state_e;

  // Arctangent of 2^-k in Q24 degrees.
  function automatic logic [30:0] atan_entry(input logic [4:0] k);
    logic [30:0] v;
    case (k)
      5'd0:  v = 31'd754974720;
      5'd1:  v = 31'd445687602;
      5'd2:  v = 31'd235489088;
      5'd3:  v = 31'd119537938;
      5'd4:  v = 31'd60000934;
      5'd5:  v = 31'd30029717;
      5'd6:  v = 31'd15018523;
      5'd7:  v = 31'd7509720;
      5'd8:  v = 31'd3754917;
      5'd9:  v = 31'd1877466;
      5'd10: v = 31'd938734;
      5'd11: v = 31'd469367;
      5'd12: v = 31'd234684;
      5'd13: v = 31'd117342;
      5'd14: v = 31'd58671;
      5'd15: v = 31'd29335;
      5'd16: v = 31'd14668;
      5'd17: v = 31'd7334;
      5'd18: v = 31'd3667;
      5'd19: v = 31'd1833;
      5'd20: v = 31'd917;
      5'd21: v = 31'd458;
      5'd22: v = 31'd229;
      5'd23: v = 31'd115;
      5'd24: v = 31'd57;
      5'd25: v = 31'd29;
      5'd26: v = 31'd14;
      5'd27: v = 31'd7;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/two_link_inverse_kinematics_select.sv
`default_nettype none
// Two-link planar inverse kinematics with pose selection. Each target point
// (x, y in 1/16 mm) sent on the slave stream yields exactly one transaction on
// the master stream carrying the chosen shoulder and elbow angles in 1/256
// degree, plus a fault flag per joint when the chosen angle lies beyond the
// joint limit (the angle then reads 0). Of the two elbow solutions the one
// with the least summed travel from the last reported pose wins; selection
// mode 1 takes the larger travel and the alternate elbow prescreen limit.
// A front queue takes up to two targets while the solver works, so the input
// keeps flowing while a result waits on the output register. The solver
// handles one target at a time: shared-multiplier work, a restoring divide
// for the elbow cosine (skipped when it clamps), a square root for the sine,
// and three passes of one CORDIC unit, each normalizing its operands by
// single-bit shifts before its iterations.
// Configuration writes are always accepted and must only be issued while
// the block is idle.
module two_link_inverse_kinematics_select #(
  parameter int CORDIC_STEPS = ikts_pkg::CORDIC_STEPS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Target stream. tdata: target_x [15:0], target_y [31:16].
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // Result stream. tdata: shoulder_angle [15:0], elbow_angle [31:16].
  // tuser: shoulder_fault [0], elbow_fault [1].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  ikts_pkg::cfg_t  cfg_q;
  ikts_pkg::item_t q_item;
  logic            q_valid, q_pop;
  logic [15:0]     shoulder, elbow;
  logic            shoulder_fault, elbow_fault;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_link_length     <= ikts_pkg::UPPER_RESET;
      cfg_q.lower_link_length     <= ikts_pkg::LOWER_RESET;
      cfg_q.tool_offset           <= ikts_pkg::TOOL_RESET;
      cfg_q.selection_mode        <= ikts_pkg::MODE_RESET;
      cfg_q.joint_limit           <= ikts_pkg::JOINT_LIM_RESET;
      cfg_q.elbow_limit_alternate <= ikts_pkg::ELBOW_ALT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ikts_pkg::REG_UPPER_LINK: cfg_q.upper_link_length <= cfg_data_i[13:0];
        ikts_pkg::REG_LOWER_LINK: cfg_q.lower_link_length <= cfg_data_i[13:0];
        ikts_pkg::REG_TOOL:       cfg_q.tool_offset       <= cfg_data_i[11:0];
        ikts_pkg::REG_MODE:       cfg_q.selection_mode    <= cfg_data_i[0];
        ikts_pkg::REG_JOINT_LIM:  cfg_q.joint_limit       <= cfg_data_i;
        ikts_pkg::REG_ELBOW_ALT:  cfg_q.elbow_limit_alternate <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: accepts targets into a two-entry queue.
  ikts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (s_axis_tdata),
    .out_valid_o(q_valid),
    .out_item_o (q_item),
    .pop_i      (q_pop)
  );

  // Back: solves one target at a time and holds the result for the sink.
  ikts_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .item_valid_i    (q_valid),
    .item_i          (q_item),
    .pop_o           (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .shoulder_o      (shoulder),
    .elbow_o         (elbow),
    .shoulder_fault_o(shoulder_fault),
    .elbow_fault_o   (elbow_fault)
  );

  assign m_axis_tdata = {elbow, shoulder};
  assign m_axis_tuser = {elbow_fault, shoulder_fault};

endmodule
`default_nettype wire

>>> design/ikts_front.sv
`default_nettype none
// Accepts target points and holds up to two of them for the solver.
module ikts_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ikts_pkg::item_t in_item_i,
  output logic                out_valid_o,
  output ikts_pkg::item_t     out_item_o,
  input  wire logic           pop_i
);

  ikts_pkg::item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = pop_i & out_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> design/ikts_cordic.sv
`default_nettype none
// Vectoring CORDIC arctangent, angle measured from the second argument.
module ikts_cordic #(
  parameter int CORDIC_STEPS = ikts_pkg::CORDIC_STEPS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ikts_pkg::cordic_req_t req_i,
  output ikts_pkg::cordic_rsp_t     rsp_o
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam int W  = ikts_pkg::CW;
  localparam logic signed [W-1:0] Z90  = W'(64'd90 << ikts_pkg::ZQ);
  localparam logic signed [W-1:0] Z180 = W'(64'd180 << ikts_pkg::ZQ);
  localparam logic signed [W-1:0] RND  = W'(64'd1 << (ikts_pkg::ANGLE_SHIFT - 1));
  localparam logic signed [W-1:0] HI   = W'(64'd1 << 30);
  localparam logic signed [W-1:0] LO   = W'(64'd1 << 29);

  ikts_pkg::cordic_state_e state_q, state_d;
  logic signed [W-1:0] cx_q, cy_q, z_q;
  logic [IW-1:0]       i_q;
  logic                xneg_q, yneg_q, done_q, done_d;
  logic signed [16:0]  res_q;

  logic signed [W-1:0] m, dx, dy, zc, rr;
  logic [4:0]          k;
  logic [30:0]         at;

  assign m  = (cx_q > cy_q) ? cx_q : cy_q;
  assign k  = 5'(i_q);
  assign dx = cy_q >>> k;
  assign dy = cx_q >>> k;
  assign at = ikts_pkg::atan_entry(k);
  assign zc = (z_q < 0) ? '0 : ((z_q > Z90) ? Z90 : z_q);
  assign rr = (z_q + RND) >>> ikts_pkg::ANGLE_SHIFT;

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = res_q;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ikts_pkg::CS_IDLE: begin
        if (req_i.start) begin
          if (req_i.xv == 0 && req_i.yv == 0) begin
            done_d = 1'b1;
          end else begin
            state_d = ikts_pkg::CS_NORM;
          end
        end
      end
      ikts_pkg::CS_NORM: begin
        if (m < HI && m >= LO) state_d = ikts_pkg::CS_ITER;
      end
      ikts_pkg::CS_ITER: begin
        if (i_q == IW'(CORDIC_STEPS - 1)) state_d = ikts_pkg::CS_CLAMP;
      end
      ikts_pkg::CS_CLAMP: state_d = ikts_pkg::CS_ROUND;
      ikts_pkg::CS_ROUND: begin
        done_d  = 1'b1;
        state_d = ikts_pkg::CS_IDLE;
      end
      default: state_d = ikts_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ikts_pkg::CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ikts_pkg::CS_IDLE: begin
        cx_q   <= (req_i.xv < 0) ? -req_i.xv : req_i.xv;
        cy_q   <= (req_i.yv < 0) ? -req_i.yv : req_i.yv;
        xneg_q <= req_i.xv < 0;
        yneg_q <= req_i.yv < 0;
        res_q  <= '0;
      end
      ikts_pkg::CS_NORM: begin
        if (m >= HI) begin
          cx_q <= cx_q >>> 1;
          cy_q <= cy_q >>> 1;
        end else if (m < LO) begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
        z_q <= '0;
        i_q <= '0;
      end
      ikts_pkg::CS_ITER: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          z_q  <= z_q + $signed({3'b000, at});
        end else begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          z_q  <= z_q - $signed({3'b000, at});
        end
        i_q <= i_q + 1'b1;
      end
      ikts_pkg::CS_CLAMP: begin
        z_q <= xneg_q ? (Z180 - zc) : zc;
      end
      ikts_pkg::CS_ROUND: begin
        res_q <= yneg_q ? -17'(rr) : 17'(rr);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> design/ikts_back.sv
`default_nettype none
// Solver sequencer: elbow cosine, sine, three arctangents and pose choice.
module ikts_back #(
  parameter int CORDIC_STEPS = ikts_pkg::CORDIC_STEPS_DEFAULT
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ikts_pkg::cfg_t  cfg_i,
  input  wire logic            item_valid_i,
  input  wire ikts_pkg::item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [15:0]          shoulder_o,
  output logic [15:0]          elbow_o,
  output logic                 shoulder_fault_o,
  output logic                 elbow_fault_o
);

  localparam int W = ikts_pkg::CW;

  function automatic logic [19:0] mag20(input logic signed [19:0] v);
    return (v < 0) ? 20'(-v) : 20'(v);
  endfunction

  ikts_pkg::back_state_e state_q, state_d;
  ikts_pkg::cordic_req_t req;
  ikts_pkg::cordic_rsp_t rsp;

  logic signed [15:0]  x_q, y_q;
  logic signed [W-1:0] num_q, den_q, by_q, bx_q;
  logic [31:0]         rem_q;
  logic [15:0]         quo_q;
  logic [4:0]          cnt_q;
  logic                neg_q;
  logic signed [17:0]  c_q;
  logic [33:0]         rad_q;
  logic [16:0]         root_q;
  logic [19:0]         srem_q;
  logic signed [16:0]  t2_q, a_q, b_q;
  logic signed [17:0]  t10_q, t11_q;
  logic [19:0]         d0_q, d1_q;
  logic                e10_q, e11_q, e20_q, e21_q;
  logic signed [16:0]  prev_s_q, prev_e_q;
  logic                ov_q, ov_d;
  logic [15:0]         os_q, oe_q;
  logic                fs_q, fe_q;

  logic signed [17:0] mul_a, mul_b, s18, t20, t21, m1, m2, m1f, m2f;
  logic signed [35:0] prod;
  logic [14:0]        l2;
  logic [15:0]        el;
  logic signed [W-1:0] num_abs;
  logic [31:0]        rem2;
  logic               dge, sge, pick0, f1, f2, out_free;
  logic [15:0]        qn;
  logic [19:0]        remt, trial;

  assign l2      = {1'b0, cfg_i.lower_link_length} + {3'b000, cfg_i.tool_offset};
  assign el      = cfg_i.selection_mode ? cfg_i.elbow_limit_alternate : cfg_i.joint_limit;
  assign s18     = $signed({1'b0, root_q});
  assign t20     = {t2_q[16], t2_q};
  assign t21     = -t20;
  assign prod    = mul_a * mul_b;
  assign num_abs = (num_q < 0) ? -num_q : num_q;
  assign rem2    = {rem_q[30:0], 1'b0};
  assign dge     = rem2 >= den_q[31:0];
  assign qn      = {quo_q[14:0], dge};
  assign remt    = {srem_q[17:0], rad_q[33:32]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign sge     = remt >= trial;
  assign out_free = !ov_q || out_ready_i;

  assign pick0 = cfg_i.selection_mode ? (d0_q >= d1_q) : (d0_q <= d1_q);
  assign m1    = pick0 ? (!e10_q ? t10_q : t11_q) : (!e11_q ? t11_q : t10_q);
  assign m2    = pick0 ? (!e20_q ? t20 : t21) : (!e21_q ? t21 : t20);
  assign f1    = mag20(20'(m1)) > {4'b0000, cfg_i.joint_limit};
  assign f2    = mag20(20'(m2)) > {4'b0000, cfg_i.joint_limit};
  assign m1f   = f1 ? '0 : m1;
  assign m2f   = f2 ? '0 : m2;

  always_comb begin
    mul_a = {{2{x_q[15]}}, x_q};
    mul_b = {{2{x_q[15]}}, x_q};
    case (state_q)
      ikts_pkg::ST_MYY: begin
        mul_a = {{2{y_q[15]}}, y_q};
        mul_b = {{2{y_q[15]}}, y_q};
      end
      ikts_pkg::ST_ML1: begin
        mul_a = $signed({4'b0000, cfg_i.upper_link_length});
        mul_b = $signed({4'b0000, cfg_i.upper_link_length});
      end
      ikts_pkg::ST_ML2: begin
        mul_a = $signed({3'b000, l2});
        mul_b = $signed({3'b000, l2});
      end
      ikts_pkg::ST_ML12: begin
        mul_a = $signed({4'b0000, cfg_i.upper_link_length});
        mul_b = $signed({3'b000, l2});
      end
      ikts_pkg::ST_CSQ: begin
        mul_a = c_q;
        mul_b = c_q;
      end
      ikts_pkg::ST_ML2S: begin
        mul_a = $signed({3'b000, l2});
        mul_b = s18;
      end
      ikts_pkg::ST_ML2C: begin
        mul_a = $signed({3'b000, l2});
        mul_b = c_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ov_d      = ov_q && !out_ready_i;
    pop_o     = 1'b0;
    req.start = 1'b0;
    req.yv    = {{(W - 16){x_q[15]}}, x_q};
    req.xv    = {{(W - 16){y_q[15]}}, y_q};
    case (state_q)
      ikts_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          pop_o   = 1'b1;
          state_d = ikts_pkg::ST_MXX;
        end
      end
      ikts_pkg::ST_MXX:  state_d = ikts_pkg::ST_MYY;
      ikts_pkg::ST_MYY:  state_d = ikts_pkg::ST_ML1;
      ikts_pkg::ST_ML1:  state_d = ikts_pkg::ST_ML2;
      ikts_pkg::ST_ML2:  state_d = ikts_pkg::ST_ML12;
      ikts_pkg::ST_ML12: state_d = ikts_pkg::ST_DCHK;
      ikts_pkg::ST_DCHK: begin
        if (den_q == 0 || num_q >= den_q || num_q <= -den_q) begin
          state_d = ikts_pkg::ST_CSQ;
        end else begin
          state_d = ikts_pkg::ST_DIV;
        end
      end
      ikts_pkg::ST_DIV: begin
        if (cnt_q == 5'd15) state_d = ikts_pkg::ST_CSQ;
      end
      ikts_pkg::ST_CSQ: state_d = ikts_pkg::ST_SQRT;
      ikts_pkg::ST_SQRT: begin
        if (cnt_q == 5'd16) state_d = ikts_pkg::ST_AT1S;
      end
      ikts_pkg::ST_AT1S: begin
        req.start = 1'b1;
        req.yv    = {{(W - 18){1'b0}}, s18};
        req.xv    = {{(W - 18){c_q[17]}}, c_q};
        state_d   = ikts_pkg::ST_AT1W;
      end
      ikts_pkg::ST_AT1W: begin
        if (rsp.done) state_d = ikts_pkg::ST_ML2S;
      end
      ikts_pkg::ST_ML2S: state_d = ikts_pkg::ST_ML2C;
      ikts_pkg::ST_ML2C: state_d = ikts_pkg::ST_AT2S;
      ikts_pkg::ST_AT2S: begin
        req.start = 1'b1;
        state_d   = ikts_pkg::ST_AT2W;
      end
      ikts_pkg::ST_AT2W: begin
        if (rsp.done) state_d = ikts_pkg::ST_AT3S;
      end
      ikts_pkg::ST_AT3S: begin
        req.start = 1'b1;
        req.yv    = by_q;
        req.xv    = bx_q;
        state_d   = ikts_pkg::ST_AT3W;
      end
      ikts_pkg::ST_AT3W: begin
        if (rsp.done) state_d = ikts_pkg::ST_SEL;
      end
      ikts_pkg::ST_SEL:  state_d = ikts_pkg::ST_DIST;
      ikts_pkg::ST_DIST: state_d = ikts_pkg::ST_OUT;
      ikts_pkg::ST_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          state_d = ikts_pkg::ST_IDLE;
        end
      end
      default: state_d = ikts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ikts_pkg::ST_IDLE;
      ov_q     <= 1'b0;
      prev_s_q <= '0;
      prev_e_q <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (state_q == ikts_pkg::ST_OUT && out_free) begin
        prev_s_q <= 17'(m1f);
        prev_e_q <= 17'(m2f);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ikts_pkg::ST_IDLE: begin
        x_q <= item_i.target_x;
        y_q <= item_i.target_y;
      end
      ikts_pkg::ST_MXX:  num_q <= W'(prod);
      ikts_pkg::ST_MYY:  num_q <= num_q + W'(prod);
      ikts_pkg::ST_ML1:  num_q <= num_q - W'(prod);
      ikts_pkg::ST_ML2:  num_q <= num_q - W'(prod);
      ikts_pkg::ST_ML12: den_q <= W'(prod) <<< 1;
      ikts_pkg::ST_DCHK: begin
        rem_q <= 32'(num_abs);
        quo_q <= '0;
        cnt_q <= '0;
        neg_q <= num_q < 0;
        if (den_q == 0) begin
          c_q <= (num_q >= 0) ? 18'sd65536 : -18'sd65536;
        end else if (num_q >= den_q) begin
          c_q <= 18'sd65536;
        end else if (num_q <= -den_q) begin
          c_q <= -18'sd65536;
        end
      end
      ikts_pkg::ST_DIV: begin
        rem_q <= dge ? (rem2 - den_q[31:0]) : rem2;
        quo_q <= qn;
        cnt_q <= cnt_q + 5'd1;
        c_q   <= neg_q ? -$signed({2'b00, qn}) : $signed({2'b00, qn});
      end
      ikts_pkg::ST_CSQ: begin
        rad_q  <= 34'd4294967296 - 34'(prod);
        root_q <= '0;
        srem_q <= '0;
        cnt_q  <= '0;
      end
      ikts_pkg::ST_SQRT: begin
        srem_q <= sge ? (remt - trial) : remt;
        root_q <= {root_q[15:0], sge};
        rad_q  <= {rad_q[31:0], 2'b00};
        cnt_q  <= cnt_q + 5'd1;
      end
      ikts_pkg::ST_AT1W: t2_q <= rsp.angle;
      ikts_pkg::ST_ML2S: by_q <= W'(prod);
      ikts_pkg::ST_ML2C: begin
        bx_q <= $signed({4'b0000, cfg_i.upper_link_length, 16'h0000}) + W'(prod);
      end
      ikts_pkg::ST_AT2W: a_q <= rsp.angle;
      ikts_pkg::ST_AT3W: b_q <= rsp.angle;
      ikts_pkg::ST_SEL: begin
        t10_q <= {a_q[16], a_q} - {b_q[16], b_q};
        t11_q <= {a_q[16], a_q} + {b_q[16], b_q};
      end
      ikts_pkg::ST_DIST: begin
        d0_q <= mag20(20'(t10_q) - 20'(prev_s_q)) + mag20(20'(t20) - 20'(prev_e_q));
        d1_q <= mag20(20'(t11_q) - 20'(prev_s_q)) + mag20(20'(t21) - 20'(prev_e_q));
        e10_q <= mag20(20'(t10_q)) > {4'b0000, cfg_i.joint_limit};
        e11_q <= mag20(20'(t11_q)) > {4'b0000, cfg_i.joint_limit};
        e20_q <= mag20(20'(t20)) > {4'b0000, el};
        e21_q <= mag20(20'(t21)) > {4'b0000, el};
      end
      ikts_pkg::ST_OUT: begin
        if (out_free) begin
          os_q <= 16'(m1f);
          oe_q <= 16'(m2f);
          fs_q <= f1;
          fe_q <= f2;
        end
      end
      default: ;
    endcase
  end

  ikts_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign out_valid_o      = ov_q;
  assign shoulder_o       = os_q;
  assign elbow_o          = oe_q;
  assign shoulder_fault_o = fs_q;
  assign elbow_fault_o    = fe_q;

endmodule
`default_nettype wire

>>> sim/tb_two_link_inverse_kinematics_select.sv
`default_nettype none
// Self-checking bench for the two-link inverse kinematics solver. Targets go
// in on the slave stream; a local solver works out the expected pose for each
// accepted transaction, and a checker compares every result transaction with
// the oldest pending pose. Both streams stall at random, and one long output
// stall forces the input queue to fill.
module tb_two_link_inverse_kinematics_select;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct packed {
    logic [15:0] shoulder;
    logic [15:0] elbow;
    logic        shoulder_flt;
    logic        elbow_flt;
  } pose_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  two_link_inverse_kinematics_select u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the configuration and of the last reported pose.
  longint upper_len, lower_len, tool_len, mode_sel, joint_lim, elbow_alt;
  longint last_shoulder, last_elbow;

  pose_t pose_q[$];
  int    errors = 0;
  bit    quiet = 1'b0;     // no idling on either side when set
  bit    hold_req = 1'b0;  // asks the receiver for one long stall

  const longint atan_q24[16] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335};

  // Vectoring arctangent of (yv, xv) in 1/256 degree, matching the fixed
  // CORDIC of the block: magnitudes are normalized to [2^29, 2^30).
  function automatic longint cordic_atan(longint yv, longint xv);
    longint unsigned ux, uy, mag;
    longint cx, cy, dx, dy, z, r;
    if (xv == 0 && yv == 0) return 0;
    ux = (xv < 0) ? -xv : xv;
    uy = (yv < 0) ? -yv : yv;
    mag = (ux > uy) ? ux : uy;
    while (mag >= (64'd1 << 30)) begin
      ux >>= 1; uy >>= 1; mag >>= 1;
    end
    while (mag < (64'd1 << 29)) begin
      ux <<= 1; uy <<= 1; mag <<= 1;
    end
    cx = ux;
    cy = uy;
    z = 0;
    for (int k = 0; k < 16; k++) begin
      dx = cy >>> k;
      dy = cx >>> k;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += atan_q24[k];
      end else begin
        cx -= dx; cy += dy; z -= atan_q24[k];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << 24)) z = longint'(90) << 24;
    if (xv < 0) z = (longint'(180) << 24) - z;
    r = (z + (longint'(1) << 15)) >>> 16;
    return (yv < 0) ? -r : r;
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Solves one target, updates the stored pose and returns the expected result.
  function automatic pose_t solve_pose(logic signed [15:0] tx, logic signed [15:0] ty);
    longint x, y, l1, l2, num, den, c, s, a, b, jl, el, d0, d1, m1, m2;
    longint unsigned rem, root, bit_w;
    longint sh[2], el_ang[2];
    bit    pick_down;
    pose_t p;
    x = longint'(tx); y = longint'(ty);
    l1 = upper_len;
    l2 = lower_len + tool_len;
    num = x * x + y * y - l1 * l1 - l2 * l2;
    den = 2 * l1 * l2;
    if (den == 0) c = (num >= 0) ? 65536 : -65536;
    else if (num >= den) c = 65536;
    else if (num <= -den) c = -65536;
    else c = num * 65536 / den;
    // Integer square root of 2^32 - c^2.
    rem = (64'd1 << 32) - c * c;
    root = 0;
    bit_w = 64'd1 << 32;
    while (bit_w > rem) bit_w >>= 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem -= root + bit_w;
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    s = root;
    el_ang[0] = cordic_atan(s, c);
    el_ang[1] = -el_ang[0];
    a = cordic_atan(x, y);
    b = cordic_atan(l2 * s, l1 * 65536 + l2 * c);
    sh[0] = a - b;
    sh[1] = a + b;
    jl = joint_lim;
    el = mode_sel ? elbow_alt : jl;
    d0 = absl(sh[0] - last_shoulder) + absl(el_ang[0] - last_elbow);
    d1 = absl(sh[1] - last_shoulder) + absl(el_ang[1] - last_elbow);
    pick_down = mode_sel ? (d0 >= d1) : (d0 <= d1);
    // A candidate failing its prescreen gives way to the other one.
    if (pick_down) begin
      m1 = (absl(sh[0]) <= jl) ? sh[0] : sh[1];
      m2 = (absl(el_ang[0]) <= el) ? el_ang[0] : el_ang[1];
    end else begin
      m1 = (absl(sh[1]) <= jl) ? sh[1] : sh[0];
      m2 = (absl(el_ang[1]) <= el) ? el_ang[1] : el_ang[0];
    end
    p.shoulder_flt = absl(m1) > jl;
    p.elbow_flt = absl(m2) > jl;
    if (p.shoulder_flt) m1 = 0;
    if (p.elbow_flt) m2 = 0;
    last_shoulder = m1;
    last_elbow = m2;
    p.shoulder = m1[15:0];
    p.elbow = m2[15:0];
    return p;
  endfunction

  // Sends one target; the expected pose is queued at the falling edge where the handshake is seen.
  task automatic send_target(logic signed [15:0] tx, logic signed [15:0] ty);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ty, tx};
    do @(negedge clk_i); while (!s_axis_tready);
    pose_q.push_back(solve_pose(tx, ty));
    @(posedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every pending pose has come back, then lets the solver settle.
  task automatic drain();
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    case (idx)
      ikts_pkg::REG_UPPER_LINK: upper_len = longint'(val[13:0]);
      ikts_pkg::REG_LOWER_LINK: lower_len = longint'(val[13:0]);
      ikts_pkg::REG_TOOL:       tool_len = longint'(val[11:0]);
      ikts_pkg::REG_MODE:       mode_sel = longint'(val[0]);
      ikts_pkg::REG_JOINT_LIM:  joint_lim = longint'(val);
      ikts_pkg::REG_ELBOW_ALT:  elbow_alt = longint'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(int up, int lo, int tl, int md, int jl, int ea);
    write_reg(ikts_pkg::REG_UPPER_LINK, 16'(up));
    write_reg(ikts_pkg::REG_LOWER_LINK, 16'(lo));
    write_reg(ikts_pkg::REG_TOOL, 16'(tl));
    write_reg(ikts_pkg::REG_MODE, 16'(md));
    write_reg(ikts_pkg::REG_JOINT_LIM, 16'(jl));
    write_reg(ikts_pkg::REG_ELBOW_ALT, 16'(ea));
  endtask

  // Random target: mostly inside the working annulus, sometimes anywhere.
  task automatic send_random();
    logic signed [15:0] tx, ty;
    if ($urandom_range(0, 4) == 0) begin
      tx = 16'($urandom);
      ty = 16'($urandom);
    end else begin
      tx = 16'($signed($urandom_range(0, 8000)) - 4000);
      ty = 16'($signed($urandom_range(0, 8000)) - 4000);
    end
    send_target(tx, ty);
  endtask

  // Directed points at reset configuration: the origin, field extremes, full
  // stretch, the dead zone near the base and ordinary reachable points.
  task automatic test_directed();
    send_target(0, 0);
    send_target(16'sh7FFF, 16'sh7FFF);
    send_target(-16'sd32768, -16'sd32768);
    send_target(-16'sd32768, 16'sh7FFF);
    send_target(16'sh7FFF, 0);
    send_target(0, 3728);
    send_target(0, -3728);
    send_target(3728, 0);
    send_target(0, 100);
    send_target(2000, 1500);
    send_target(-2000, 1500);
    send_target(2000, -1500);
    send_target(-2000, -1500);
    send_target(2000, 1500);
    send_target(1, -1);
    send_target(-1, 0);
    end_burst();
    drain();
  endtask

  // Zero link lengths force the cosine to its rails.
  task automatic test_zero_links();
    set_config(0, 1600, 528, 0, 30720, 32000);
    send_target(1000, 1000);
    send_target(0, 0);
    end_burst();
    drain();
    set_config(0, 0, 0, 0, 30720, 32000);
    send_target(0, 0);
    send_target(-300, 20);
    end_burst();
    drain();
  endtask

  // Greater-travel mode with the limit registers at their extremes.
  task automatic test_modes_and_limits();
    set_config(16383, 16383, 4095, 1, 46080, 0);
    repeat (6) send_random();
    send_target(-16'sd32768, 16'sh7FFF);
    end_burst();
    drain();
    set_config(1600, 1200, 0, 1, 0, 46080);
    repeat (6) send_random();
    end_burst();
    drain();
  endtask

  // Input keeps coming while the output is held off for a long stretch.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_random();
    end_burst();
    drain();
  endtask

  task automatic test_random();
    int up, lo, tl;
    for (int phase = 0; phase < 6; phase++) begin
      up = $urandom_range(200, 3000);
      lo = $urandom_range(200, 3000);
      tl = $urandom_range(0, 4095);
      set_config(up, lo, tl, phase % 2, $urandom_range(20000, 46080),
                 $urandom_range(0, 46080));
      if (phase == 5) quiet = 1'b1;
      repeat (100) send_random();
      end_burst();
      drain();
    end
  endtask

  // Receiver: random stall bursts, or one long stall on request.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker. Handshake signals are stable at the falling edge, so a
  // transaction seen here completes at the next rising edge.
  pose_t exp_pose;
  always @(negedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pose_q.size() == 0) begin
        $error("result transaction with no pending target: tdata=%h", m_axis_tdata);
        errors++;
      end else begin
        exp_pose = pose_q.pop_front();
        if (m_axis_tdata[15:0] !== exp_pose.shoulder) begin
          $error("shoulder_angle expected %0d actual %0d",
                 $signed(exp_pose.shoulder), $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== exp_pose.elbow) begin
          $error("elbow_angle expected %0d actual %0d",
                 $signed(exp_pose.elbow), $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tuser[0] !== exp_pose.shoulder_flt) begin
          $error("shoulder_fault expected %0b actual %0b",
                 exp_pose.shoulder_flt, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== exp_pose.elbow_flt) begin
          $error("elbow_fault expected %0b actual %0b",
                 exp_pose.elbow_flt, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction happens on any channel.
  int quiet_cycles = 0;
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    upper_len = longint'(ikts_pkg::UPPER_RESET);
    lower_len = longint'(ikts_pkg::LOWER_RESET);
    tool_len = longint'(ikts_pkg::TOOL_RESET);
    mode_sel = longint'(ikts_pkg::MODE_RESET);
    joint_lim = longint'(ikts_pkg::JOINT_LIM_RESET);
    elbow_alt = longint'(ikts_pkg::ELBOW_ALT_RESET);
    last_shoulder = 0;
    last_elbow = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_links();
    test_modes_and_limits();
    test_backpressure();
    test_random();
    if (pose_q.size() != 0) begin
      $error("%0d expected results never arrived", pose_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
design/ikts_pkg.sv
design/ikts_front.sv
design/ikts_cordic.sv
design/ikts_back.sv
design/two_link_inverse_kinematics_select.sv
sim/tb_two_link_inverse_kinematics_select.sv
